[sv/sqvg_pkg.sv]
// Shared types, constants and helper functions for the sprite quad vertex generator.
// Holds the port payload structs, the inter-stage structs and the quarter-wave sine table.
// No dependencies.
package sqvg_pkg;

  // Batch geometry: the batch size is a power of two, so the slot wraps by masking.
  localparam int SPRITES_PER_BATCH = 4096;
  localparam int SLOT_W            = 12;
  localparam int VSLOT_W           = SLOT_W + 2;

  // Arithmetic widths along the pipeline.
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int HALF_SHIFT = 17;
  localparam int HALF_W     = PROD_W - HALF_SHIFT;
  localparam int TRIG_W     = 16;
  localparam int ROT_W      = HALF_W + TRIG_W;
  localparam int ROT_SHIFT  = 15;
  localparam int TERM_W     = ROT_W - ROT_SHIFT + 1;
  localparam int SUM_W      = TERM_W + 2;

  // Corner numbering and per-corner patterns, bit i belongs to corner i.
  localparam logic [1:0] LAST_CORNER = 2'd3;
  localparam logic [3:0] X_POS_PAT   = 4'b0110;  // corners that use +hx
  localparam logic [3:0] Y_POS_PAT   = 4'b0011;  // corners that use +hy
  localparam logic [3:0] TEX_U_PAT   = 4'b0110;  // corners that pick the end u
  localparam logic [3:0] TEX_V_PAT   = 4'b0011;  // corners that pick the end v

  // Color conversion constants in Q2.14.
  localparam logic [15:0] COLOR_ONE  = 16'd16384;
  localparam logic [22:0] COLOR_HALF = 23'd8192;

  // Quarter-wave sine table: round(32767 * sin(pi * i / 2048)) for i = 0..1024.
  localparam int  QSIN_LAST = 1024;
  localparam real QSIN_PI   = 3.14159265358979323846;
  typedef logic [14:0] qsin_tab_t [0:QSIN_LAST];

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    real       ang;
    for (int i = 0; i <= QSIN_LAST; i++) begin
      ang    = QSIN_PI * real'(i) / 2048.0;
      tab[i] = 15'($rtoi(32767.0 * $sin(ang) + 0.5));
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // Full-turn sine from a 12-bit angle, built from the quarter-wave table.
  function automatic logic signed [TRIG_W-1:0] sine12(logic [11:0] k);
    logic [1:0]               q;
    logic [10:0]              idx;
    logic signed [TRIG_W-1:0] v;
    q   = k[11:10];
    idx = q[0] ? (11'd1024 - {1'b0, k[9:0]}) : {1'b0, k[9:0]};
    v   = $signed({1'b0, QSIN_TAB[idx]});
    return q[1] ? -v : v;
  endfunction

  // Clamp one Q2.14 channel to [0, 1] and scale it to a rounded byte.
  function automatic logic [7:0] chan_byte(logic [15:0] raw);
    logic [14:0] c;
    logic [22:0] scaled;
    if (raw[15]) begin
      c = '0;
    end else if (raw > COLOR_ONE) begin
      c = COLOR_ONE[14:0];
    end else begin
      c = raw[14:0];
    end
    scaled = {c, 8'b0} - 23'(c) + COLOR_HALF;
    return scaled[21:14];
  endfunction

  // Input item: one sprite.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [15:0]        rotation_angle;
    logic [31:0]        uv_start;
    logic [31:0]        uv_end;
    logic [1:0]         flip_bits;
    logic [63:0]        color_packed;
    logic [11:0]        sprite_slot;
  } sprite_t;

  // Result item: one corner vertex.
  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [31:0]        color_rgba;
    logic [VSLOT_W-1:0] vertex_slot;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  // Handshake between the pipeline control and one stage.
  typedef struct packed {
    logic load;
    logic valid_in;
  } stage_ctl_t;

  // After setup: extent products, sine and cosine, packed color.
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [TRIG_W-1:0]  sn;
    logic signed [TRIG_W-1:0]  cs;
    logic [31:0]               uv_start;
    logic [31:0]               uv_end;
    logic [1:0]                flip;
    logic [31:0]               rgba;
    logic [SLOT_W-1:0]         slot;
  } setup_t;

  // After rotation: the four products of half extents and trig values.
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [ROT_W-1:0]   xc;
    logic signed [ROT_W-1:0]   ys;
    logic signed [ROT_W-1:0]   xs;
    logic signed [ROT_W-1:0]   yc;
    logic [31:0]               uv_start;
    logic [31:0]               uv_end;
    logic [1:0]                flip;
    logic [31:0]               rgba;
    logic [SLOT_W-1:0]         slot;
  } rotate_t;

endpackage

[sv/sqvg_setup.sv]
// First pipeline stage: extent products, sine/cosine lookup, color packing, slot wrap.
// Depends on sqvg_pkg.
module sqvg_setup
  import sqvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  sprite_t    sprite,
  output logic       valid,
  output setup_t     stage
);

  setup_t     stage_next;
  logic [11:0] angle_k;

  // One 32x32 product per axis, the trig lookup and the color bytes.
  always_comb begin
    angle_k             = sprite.rotation_angle[15:4];
    stage_next.pos_x    = $signed(sprite.pos_x);
    stage_next.pos_y    = $signed(sprite.pos_y);
    stage_next.prod_x   = $signed(sprite.size_x) * $signed(sprite.scale_x);
    stage_next.prod_y   = $signed(sprite.size_y) * $signed(sprite.scale_y);
    stage_next.sn       = sine12(angle_k);
    stage_next.cs       = sine12(angle_k + 12'd1024);
    stage_next.uv_start = sprite.uv_start;
    stage_next.uv_end   = sprite.uv_end;
    stage_next.flip     = sprite.flip_bits;
    stage_next.rgba     = {chan_byte(sprite.color_packed[63:48]),
                           chan_byte(sprite.color_packed[47:32]),
                           chan_byte(sprite.color_packed[31:16]),
                           chan_byte(sprite.color_packed[15:0])};
    stage_next.slot     = sprite.sprite_slot & SLOT_W'(SPRITES_PER_BATCH - 1);
  end

  // Valid bit follows the transfer into this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stage <= stage_next;
    end
  end

endmodule

[sv/sqvg_rotate.sv]
// Second pipeline stage: half extents times sine and cosine, four products per sprite.
// Depends on sqvg_pkg.
module sqvg_rotate
  import sqvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  setup_t     prev,
  output logic       valid,
  output rotate_t    stage
);

  rotate_t                  stage_next;
  logic signed [HALF_W-1:0] hx;
  logic signed [HALF_W-1:0] hy;

  // Half extents are the products floor-shifted by 17, then each meets sine and cosine.
  always_comb begin
    hx                  = $signed(prev.prod_x[PROD_W-1:HALF_SHIFT]);
    hy                  = $signed(prev.prod_y[PROD_W-1:HALF_SHIFT]);
    stage_next.pos_x    = prev.pos_x;
    stage_next.pos_y    = prev.pos_y;
    stage_next.xc       = hx * prev.cs;
    stage_next.ys       = hy * prev.sn;
    stage_next.xs       = hx * prev.sn;
    stage_next.yc       = hy * prev.cs;
    stage_next.uv_start = prev.uv_start;
    stage_next.uv_end   = prev.uv_end;
    stage_next.flip     = prev.flip;
    stage_next.rgba     = prev.rgba;
    stage_next.slot     = prev.slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stage <= stage_next;
    end
  end

endmodule

[sv/sqvg_corner.sv]
// Final stages: floor-shifted rotation terms held per sprite, then one corner per cycle
// summed, saturated and registered onto the result ports. Depends on sqvg_pkg.
module sqvg_corner
  import sqvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  rotate_t    prev,
  output logic       free,
  output logic       strobe,
  output vertex_t    vertex
);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [TERM_W-1:0]  xc_pos;
    logic signed [TERM_W-1:0]  xc_neg;
    logic signed [TERM_W-1:0]  ys_pos;
    logic signed [TERM_W-1:0]  ys_neg;
    logic signed [TERM_W-1:0]  xs_pos;
    logic signed [TERM_W-1:0]  xs_neg;
    logic signed [TERM_W-1:0]  yc_pos;
    logic signed [TERM_W-1:0]  yc_neg;
    logic [31:0]               uv_start;
    logic [31:0]               uv_end;
    logic [1:0]                flip;
    logic [31:0]               rgba;
    logic [SLOT_W-1:0]         slot;
  } hold_t;

  hold_t                     hold;
  hold_t                     hold_next;
  logic                      valid;
  logic [1:0]                cnt;
  vertex_t                   vertex_next;
  logic signed [TERM_W-1:0]  term_x;
  logic signed [TERM_W-1:0]  term_xs;
  logic signed [TERM_W-1:0]  term_y;
  logic signed [TERM_W-1:0]  term_yc;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic                      sel_u;
  logic                      sel_v;

  // floor(p / 2^15), sign-extended by one bit.
  function automatic logic signed [TERM_W-1:0] floor_pos(logic signed [ROT_W-1:0] p);
    return TERM_W'($signed(p[ROT_W-1:ROT_SHIFT]));
  endfunction

  // floor(-p / 2^15) is minus the ceiling of p / 2^15.
  function automatic logic signed [TERM_W-1:0] floor_neg(logic signed [ROT_W-1:0] p);
    logic signed [TERM_W-1:0] up;
    up = TERM_W'($signed(p[ROT_W-1:ROT_SHIFT])) + TERM_W'(|p[ROT_SHIFT-1:0]);
    return -up;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){v[SUM_W-1]}}) begin
      return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return v[COORD_W-1:0];
  endfunction

  // Both signs of each rotation term, so a corner only selects.
  always_comb begin
    hold_next.pos_x    = prev.pos_x;
    hold_next.pos_y    = prev.pos_y;
    hold_next.xc_pos   = floor_pos(prev.xc);
    hold_next.xc_neg   = floor_neg(prev.xc);
    hold_next.ys_pos   = floor_pos(prev.ys);
    hold_next.ys_neg   = floor_neg(prev.ys);
    hold_next.xs_pos   = floor_pos(prev.xs);
    hold_next.xs_neg   = floor_neg(prev.xs);
    hold_next.yc_pos   = floor_pos(prev.yc);
    hold_next.yc_neg   = floor_neg(prev.yc);
    hold_next.uv_start = prev.uv_start;
    hold_next.uv_end   = prev.uv_end;
    hold_next.flip     = prev.flip;
    hold_next.rgba     = prev.rgba;
    hold_next.slot     = prev.slot;
  end

  // The held sprite is released once its last corner goes out.
  assign free = !valid || (cnt == LAST_CORNER);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (ctl.load) begin
      valid <= ctl.valid_in;
      cnt   <= '0;
    end else if (valid) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hold <= hold_next;
    end
  end

  // Corner assembly: pick the signed terms, add to the center, saturate.
  always_comb begin
    term_x  = X_POS_PAT[cnt] ? hold.xc_pos : hold.xc_neg;
    term_xs = X_POS_PAT[cnt] ? hold.xs_pos : hold.xs_neg;
    term_y  = Y_POS_PAT[cnt] ? hold.ys_pos : hold.ys_neg;
    term_yc = Y_POS_PAT[cnt] ? hold.yc_pos : hold.yc_neg;
    sum_x   = SUM_W'(hold.pos_x) + SUM_W'(term_x) - SUM_W'(term_y);
    sum_y   = SUM_W'(hold.pos_y) + SUM_W'(term_xs) + SUM_W'(term_yc);
    sel_u   = TEX_U_PAT[cnt] ^ hold.flip[0];
    sel_v   = TEX_V_PAT[cnt] ^ hold.flip[1];

    vertex_next.vertex_x    = sat32(sum_x);
    vertex_next.vertex_y    = sat32(sum_y);
    vertex_next.tex_u       = sel_u ? hold.uv_end[15:0] : hold.uv_start[15:0];
    vertex_next.tex_v       = sel_v ? hold.uv_end[31:16] : hold.uv_start[31:16];
    vertex_next.color_rgba  = hold.rgba;
    vertex_next.vertex_slot = {hold.slot, cnt};
    vertex_next.corner      = cnt;
    vertex_next.last        = (cnt == LAST_CORNER);
  end

  // Result register: one corner transfer per cycle while a sprite is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid) begin
      vertex <= vertex_next;
    end
  end

endmodule

[sv/sprite_quad_vertex_gen.sv]
// Top level of the sprite quad vertex generator: pipeline control and stage wiring.
// Depends on sqvg_pkg, sqvg_setup, sqvg_rotate and sqvg_corner.
//
//   Channel  Ports                 Direction  Transfer
//   sprite   start, busy, sprite   in         start high while busy low
//   vertex   strobe, vertex        out        every cycle strobe is high
//
// Each sprite gives four vertex transfers on consecutive cycles; the first is strobed
// once the sprite has passed the setup, rotate, hold and result registers. The single
// result port sets the sustained rate, but new sprites are still taken: up to two more
// sprites wait in the earlier stages while one is being emitted.
// Reset clears all valid bits, the corner counter and the strobe; nothing else needs it.
// The receiver cannot stall; busy rises only while every stage is occupied.
module sprite_quad_vertex_gen
  import sqvg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  sprite_t sprite,
  output logic    strobe,
  output vertex_t vertex
);

  logic       s1_valid;
  logic       s2_valid;
  logic       s3_free;
  logic       s2_free;
  logic       s1_free;
  setup_t     s1;
  rotate_t    s2;
  stage_ctl_t setup_ctl;
  stage_ctl_t rotate_ctl;
  stage_ctl_t corner_ctl;

  // A stage moves when it is empty or the one after it moves.
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign busy    = !s1_free;

  assign setup_ctl  = '{load: s1_free, valid_in: start};
  assign rotate_ctl = '{load: s2_free, valid_in: s1_valid};
  assign corner_ctl = '{load: s3_free, valid_in: s2_valid};

  sqvg_setup u_setup (
    .clk    (clk),
    .rst    (rst),
    .ctl    (setup_ctl),
    .sprite (sprite),
    .valid  (s1_valid),
    .stage  (s1)
  );

  sqvg_rotate u_rotate (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rotate_ctl),
    .prev  (s1),
    .valid (s2_valid),
    .stage (s2)
  );

  sqvg_corner u_corner (
    .clk    (clk),
    .rst    (rst),
    .ctl    (corner_ctl),
    .prev   (s2),
    .free   (s3_free),
    .strobe (strobe),
    .vertex (vertex)
  );

`ifndef SYNTHESIS
  // An accepted sprite lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> s1_valid)
    else $error("accepted sprite missing from the first stage");

  // Busy only when the first two stages are both occupied.
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> (s1_valid && s2_valid))
    else $error("busy raised with room in the pipeline");

  // The corners of one sprite go out on consecutive cycles, in order.
  a_corner_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && (vertex.corner != LAST_CORNER)) |=>
      (strobe && (vertex.corner == $past(vertex.corner) + 2'd1)))
    else $error("corner sequence broken");

  // The last flag marks exactly the fourth corner.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (vertex.last == (vertex.corner == LAST_CORNER)))
    else $error("last flag does not match the corner number");
`endif

endmodule

[dv/sprite_quad_vertex_gen_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sprite_quad_vertex_gen: directed sprite table, then random sprites.
// Predicts or takes typed-in corners for each accepted sprite and checks every vertex transfer.
// Depends on sqvg_pkg (sprite_t, vertex_t) and the sprite_quad_vertex_gen RTL.
module sprite_quad_vertex_gen_tb
  import sqvg_pkg::*;
();

  localparam int  DIR_N       = 20;
  localparam int  RAND_N      = 400;
  localparam int  QUIET_LIMIT = 400;
  localparam int  DRAIN_WAIT  = 10;
  localparam real PI_VAL      = 3.14159265358979323846;

  // Corner patterns, bit i belongs to corner i.
  localparam logic [3:0] X_PLUS = 4'b0110;  // corners at +hx
  localparam logic [3:0] Y_PLUS = 4'b0011;  // corners at +hy
  localparam logic [3:0] U_END  = 4'b0110;  // corners that take the end u
  localparam logic [3:0] V_END  = 4'b0011;  // corners that take the end v

  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  typedef vertex_t [3:0] quad_t;

  // One directed row; the expected corners are typed in only where typed is set.
  typedef struct packed {
    sprite_t          s;
    logic             typed;
    logic [3:0][31:0] xs;
    logic [3:0][31:0] ys;
    logic [3:0][15:0] us;
    logic [3:0][15:0] vs;
    logic [31:0]      rgba;
    logic [13:0]      vbase;
  } dir_row_t;

  // Per-sprite note queued before its transfer: a typed quad or a request to predict.
  typedef struct packed {
    logic  typed;
    quad_t quad;
  } quad_note_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  sprite_t sprite;
  logic    strobe;
  vertex_t vertex;

  dir_row_t   dir_tab [DIR_N];
  quad_note_t pending_quads[$];
  vertex_t    vertices_due[$];
  int         fail_count = 0;
  int         quiet_cycles = 0;

  sprite_quad_vertex_gen dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .sprite (sprite),
    .strobe (strobe),
    .vertex (vertex)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sine in Q1.15 from a 12-bit angle, folded onto the first quadrant.
  function automatic longint trig_q15(logic [11:0] k);
    int     idx;
    longint v;
    idx = k[10] ? 1024 - int'(k[9:0]) : int'(k[9:0]);
    v   = longint'($rtoi(32767.0 * $sin(PI_VAL * real'(idx) / 2048.0) + 0.5));
    return k[11] ? -v : v;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return SMAX;
    if (v < -64'sd2147483648) return SMIN;
    return v[31:0];
  endfunction

  // Clamp a Q2.14 channel to [0, 1] and round it to a byte.
  function automatic logic [7:0] color_byte(logic [15:0] raw);
    longint c;
    c = longint'($signed(raw));
    if (c < 0) c = 0;
    if (c > 16384) c = 16384;
    return 8'((c * 255 + 8192) >>> 14);
  endfunction

  // Predicted four corners of one sprite in emission order.
  function automatic quad_t corners_of(sprite_t s);
    quad_t       q;
    longint      px, py, hx, hy, lx, ly, sn, cs, wx, wy;
    logic [11:0] k;
    logic [31:0] rgba;
    px = longint'($signed(s.pos_x));
    py = longint'($signed(s.pos_y));
    hx = (longint'($signed(s.size_x)) * longint'($signed(s.scale_x))) >>> 17;
    hy = (longint'($signed(s.size_y)) * longint'($signed(s.scale_y))) >>> 17;
    k  = s.rotation_angle[15:4];
    sn = trig_q15(k);
    cs = trig_q15(k + 12'd1024);
    for (int ch = 0; ch < 4; ch++) begin
      rgba[8*ch +: 8] = color_byte(s.color_packed[16*ch +: 16]);
    end
    for (int i = 0; i < 4; i++) begin
      lx = X_PLUS[i] ? hx : -hx;
      ly = Y_PLUS[i] ? hy : -hy;
      wx = px + ((lx * cs) >>> 15) - ((ly * sn) >>> 15);
      wy = py + ((lx * sn) >>> 15) + ((ly * cs) >>> 15);
      q[i].vertex_x    = sat32(wx);
      q[i].vertex_y    = sat32(wy);
      q[i].tex_u       = (U_END[i] ^ s.flip_bits[0]) ? s.uv_end[15:0] : s.uv_start[15:0];
      q[i].tex_v       = (V_END[i] ^ s.flip_bits[1]) ? s.uv_end[31:16] : s.uv_start[31:16];
      q[i].color_rgba  = rgba;
      q[i].vertex_slot = {s.sprite_slot, 2'(i)};
      q[i].corner      = 2'(i);
      q[i].last        = (i == 3);
    end
    return q;
  endfunction

  function automatic sprite_t spr(logic [31:0] px, logic [31:0] py, logic [31:0] sx,
                                  logic [31:0] sy, logic [31:0] kx, logic [31:0] ky,
                                  logic [15:0] ang, logic [31:0] uvs, logic [31:0] uve,
                                  logic [1:0] flip, logic [63:0] col, logic [11:0] slot);
    sprite_t s;
    s.pos_x          = px;
    s.pos_y          = py;
    s.size_x         = sx;
    s.size_y         = sy;
    s.scale_x        = kx;
    s.scale_y        = ky;
    s.rotation_angle = ang;
    s.uv_start       = uvs;
    s.uv_end         = uve;
    s.flip_bits      = flip;
    s.color_packed   = col;
    s.sprite_slot    = slot;
    return s;
  endfunction

  function automatic dir_row_t plain(sprite_t s);
    dir_row_t r;
    r   = '0;
    r.s = s;
    return r;
  endfunction

  // Random sprite: mostly moderate geometry, some full-range, some degenerate.
  function automatic sprite_t random_sprite();
    sprite_t s;
    int      mode;
    mode             = $urandom_range(0, 9);
    s.pos_x          = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    s.pos_y          = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    s.size_x         = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    s.size_y         = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    s.scale_x        = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    s.scale_y        = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (mode < 2) begin
      s.pos_x   = $urandom;
      s.pos_y   = $urandom;
      s.size_x  = $urandom;
      s.size_y  = $urandom;
      s.scale_x = $urandom;
      s.scale_y = $urandom;
    end else if (mode == 8) begin
      if ($urandom_range(0, 1)) begin
        s.size_x = '0;
      end else begin
        s.scale_y = '0;
      end
    end else if (mode == 9) begin
      s.size_x  = $urandom_range(0, 64) - 32;
      s.size_y  = $urandom_range(0, 64) - 32;
      s.scale_x = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      s.scale_y = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    end
    s.rotation_angle = 16'($urandom_range(0, 65535));
    s.uv_start       = $urandom;
    s.uv_end         = $urandom;
    s.flip_bits      = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      s.color_packed = {$urandom, $urandom};
    end else begin
      for (int ch = 0; ch < 4; ch++) begin
        s.color_packed[16*ch +: 16] = 16'($urandom_range(0, 16384));
      end
    end
    s.sprite_slot = 12'($urandom_range(0, 4095));
    return s;
  endfunction

  // Directed sprites: extremes, all flips, color clamping, saturation and angle corners.
  initial begin
    // All zero: every corner at the origin.
    dir_tab[0] = '{spr(0, 0, 0, 0, 0, 0, 16'h0, 0, 0, 2'd0, 64'h0, 12'h0), 1'b1,
                   '0, '0, '0, '0, 32'h0, 14'd0};
    // Zero size collapses to the centre; full-scale color; top slot.
    dir_tab[1] = '{spr(32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                       16'h1234, 32'h2222_1111, 32'h4444_3333, 2'd0,
                       64'h4000_4000_4000_4000, 12'hFFF), 1'b1,
                   {4{32'h0001_0000}}, {4{32'hFFFF_0000}},
                   {16'h1111, 16'h3333, 16'h3333, 16'h1111},
                   {16'h2222, 16'h2222, 16'h4444, 16'h4444}, 32'hFFFF_FFFF, 14'h3FFC};
    // Both flips; negative, over-range, half and one color channels.
    dir_tab[2] = '{spr(32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                       16'h1234, 32'h2222_1111, 32'h4444_3333, 2'd3,
                       64'h4000_2000_7FFF_8000, 12'd5), 1'b1,
                   {4{32'h0001_0000}}, {4{32'hFFFF_0000}},
                   {16'h3333, 16'h1111, 16'h1111, 16'h3333},
                   {16'h4444, 16'h4444, 16'h2222, 16'h2222}, 32'hFF80_FF00, 14'd20};
    // Largest extents at angle zero saturate every corner.
    dir_tab[3] = '{spr(0, 0, SMIN, SMIN, SMIN, SMIN, 16'h0, 0, 0, 2'd0, 64'h0, 12'd1), 1'b1,
                   {SMIN, SMAX, SMAX, SMIN}, {SMIN, SMIN, SMAX, SMAX},
                   '0, '0, 32'h0, 14'd4};
    // Same at a half turn: every corner saturates the other way.
    dir_tab[4] = '{spr(0, 0, SMIN, SMIN, SMIN, SMIN, 16'h8000, 0, 0, 2'd0, 64'h0, 12'd2), 1'b1,
                   {SMAX, SMIN, SMIN, SMAX}, {SMAX, SMAX, SMIN, SMIN},
                   '0, '0, 32'h0, 14'd8};
    dir_tab[5]  = plain(spr(32'h0064_0000, 32'h0032_0000, 32'h000A_0000, 32'h0004_0000,
                            32'h0001_0000, 32'h0001_0000, 16'h4000, 32'h1000_0000,
                            32'h0000_1000, 2'd0, 64'h3000_2000_1000_0800, 12'd3));
    dir_tab[6]  = plain(spr(32'hFF00_0000, 32'h0010_0000, 32'h0020_0000, 32'h0008_0000,
                            32'hFFFE_0000, 32'h0001_8000, 16'hC000, 32'h0800_0800,
                            32'hF800_F800, 2'd1, 64'h4000_4000_4000_4000, 12'd7));
    dir_tab[7]  = plain(spr(SMAX, SMIN, SMAX, SMAX, SMAX, SMAX, 16'h2000, 32'hFFFF_FFFF,
                            32'h0, 2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 12'h800));
    dir_tab[8]  = plain(spr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1,
                            16'hFFFF, 32'h0001_0001, 32'hFFFE_FFFE, 2'd3,
                            64'h0001_0001_0001_0001, 12'hAAA));
    dir_tab[9]  = plain(spr(32'h1234_5678, 32'h8765_4321, 32'hFFFC_8000, 32'h0003_8000,
                            32'h0001_0000, 32'hFFFF_0000, 16'h000F, 32'hFFFF_FFFF,
                            32'h8000_7FFF, 2'd1, 64'h7FFF_7FFF_7FFF_7FFF, 12'h555));
    dir_tab[10] = plain(spr(32'h0, 32'h0, 32'h0010_0000, 32'h0010_0000, 32'h0001_0000,
                            32'h0001_0000, 16'h6000, 32'h7FFF_8000, 32'h0,
                            2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 12'd100));
    dir_tab[11] = plain(spr(32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h0002_0000, 32'h0002_0000,
                            32'h0001_0000, 32'h0001_0000, 16'h0, 32'h0, 32'h0,
                            2'd0, 64'h0, 12'd9));
    dir_tab[12] = plain(spr(32'h8000_0010, 32'h8000_0010, 32'h0002_0000, 32'h0002_0000,
                            32'h0001_0000, 32'h0001_0000, 16'h0, 32'h0, 32'h0,
                            2'd0, 64'h0, 12'd10));
    dir_tab[13] = plain(spr(32'h0, 32'h0, SMIN, SMAX, SMAX, SMIN, 16'h1000, 32'h0, 32'h0,
                            2'd0, 64'h0, 12'd11));
    dir_tab[14] = plain(spr(32'h0100_0000, 32'h0200_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 32'h0001_0000, 16'h0800, 32'h0, 32'h0,
                            2'd0, 64'h4001_3FFF_0001_0000, 12'd12));
    dir_tab[15] = plain(spr(32'h5555_5555, 32'hAAAA_AAAA, 32'h0333_3333, 32'hFCCC_CCCD,
                            32'h0002_8000, 32'h0000_4000, 16'h5555, 32'h5A5A_A5A5,
                            32'hA5A5_5A5A, 2'd1, 64'h1234_5678_9ABC_DEF0, 12'h800));
    dir_tab[16] = plain(spr(32'h0, 32'h0, SMAX, SMAX, 32'h0, 32'h0, 16'h9000, 32'h0,
                            32'h0, 2'd2, 64'h0, 12'd13));
    dir_tab[17] = plain(spr(32'h0, 32'h0, 32'h7FFF_0000, 32'h7FFF_0000, 32'h0001_0000,
                            32'h0001_0000, 16'h0010, 32'h0, 32'h0, 2'd0, 64'h0, 12'd14));
    dir_tab[18] = plain(spr(32'hFFFF_FFFF, 32'h0, 32'h7FFF_0000, 32'hFFFF_0000,
                            32'h0001_0000, 32'h0001_0000, 16'hFFF0, 32'h0, 32'h0,
                            2'd3, 64'h0, 12'd15));
    dir_tab[19] = plain(spr(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 16'h0, 32'h0, 32'h0, 2'd0,
                            64'h0080_0040_003F_0020, 12'd16));
  end

  // Present one sprite after a gap and hold it until the transfer; ends on a falling edge.
  task automatic send_sprite(input sprite_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    sprite <= s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stimulus: reset, directed table, random sprites, then drain and report.
  initial begin
    sprite_t    item;
    quad_note_t note;
    int         gap;
    rst    = 1'b1;
    start  = 1'b0;
    sprite = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int n = 0; n < DIR_N + RAND_N; n++) begin
      note = '0;
      if (n < DIR_N) begin
        item       = dir_tab[n].s;
        note.typed = dir_tab[n].typed;
        for (int i = 0; i < 4; i++) begin
          note.quad[i].vertex_x    = dir_tab[n].xs[i];
          note.quad[i].vertex_y    = dir_tab[n].ys[i];
          note.quad[i].tex_u       = dir_tab[n].us[i];
          note.quad[i].tex_v       = dir_tab[n].vs[i];
          note.quad[i].color_rgba  = dir_tab[n].rgba;
          note.quad[i].vertex_slot = dir_tab[n].vbase + 14'(i);
          note.quad[i].corner      = 2'(i);
          note.quad[i].last        = (i == 3);
        end
      end else begin
        item = random_sprite();
      end
      // Every third stretch of fifty sprites runs back to back.
      gap = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 10);
      pending_quads.push_back(note);
      send_sprite(item, gap);
    end
    start <= 1'b0;
    while (vertices_due.size() != 0 || pending_quads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  task automatic compare_vertex(input vertex_t want, input vertex_t got);
    if (got.vertex_x !== want.vertex_x) begin
      $error("vertex_x: expected %0d, got %0d", want.vertex_x, got.vertex_x);
      fail_count++;
    end
    if (got.vertex_y !== want.vertex_y) begin
      $error("vertex_y: expected %0d, got %0d", want.vertex_y, got.vertex_y);
      fail_count++;
    end
    if (got.tex_u !== want.tex_u) begin
      $error("tex_u: expected %h, got %h", want.tex_u, got.tex_u);
      fail_count++;
    end
    if (got.tex_v !== want.tex_v) begin
      $error("tex_v: expected %h, got %h", want.tex_v, got.tex_v);
      fail_count++;
    end
    if (got.color_rgba !== want.color_rgba) begin
      $error("color_rgba: expected %h, got %h", want.color_rgba, got.color_rgba);
      fail_count++;
    end
    if (got.vertex_slot !== want.vertex_slot) begin
      $error("vertex_slot: expected %0d, got %0d", want.vertex_slot, got.vertex_slot);
      fail_count++;
    end
    if (got.corner !== want.corner) begin
      $error("corner: expected %0d, got %0d", want.corner, got.corner);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  // Check each vertex transfer, then queue the corners of a sprite accepted at this edge.
  always @(posedge clk) begin
    quad_note_t note;
    quad_t      quad;
    if (!rst) begin
      if (strobe) begin
        if (vertices_due.size() == 0) begin
          $error("vertex transfer with no vertex expected");
          fail_count++;
        end else begin
          compare_vertex(vertices_due.pop_front(), vertex);
        end
      end
      if (start && !busy && pending_quads.size() != 0) begin
        note = pending_quads.pop_front();
        quad = note.typed ? note.quad : corners_of(sprite);
        for (int i = 0; i < 4; i++) vertices_due.push_back(quad[i]);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
